[rtl/ftprl_pkg.sv]
// ----------------------------------------------------------------------------
// ftprl_pkg
// types and constants shared by the reply line parser modules
// ----------------------------------------------------------------------------
package ftprl_pkg;

	typedef enum logic [2:0] {
		K_LF,
		K_DIGIT,
		K_SPACE,
		K_COMMA,
		K_LPAREN,
		K_RPAREN,
		K_OTHER
	} kind_t;

	typedef struct packed {
		logic       restart;
		kind_t      kind;
		logic [3:0] digit;
	} item_t;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [3:0] PS_BEFORE = 4'd0;
	localparam logic [3:0] PS_FIELD5 = 4'd5;
	localparam logic [3:0] PS_FIELD6 = 4'd6;
	localparam logic [3:0] PS_DONE   = 4'd7;
	localparam logic [3:0] PS_BAD    = 4'd8;

	localparam logic [9:0] SIZE_CODE    = 10'd213;
	localparam logic [7:0] PREFIX_LEN   = 8'd3;
	localparam logic [7:0] MIN_LINE_LEN = 8'd4;
	localparam logic [7:0] LIMIT_RESET  = 8'd255;

endpackage

[rtl/ftprl_front.sv]
// ----------------------------------------------------------------------------
// ftprl_front
// accepts input transfers, drops carriage returns (except on restart transfers) and classifies each byte
// ----------------------------------------------------------------------------
module ftprl_front
	import ftprl_pkg::*;
(
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] data_byte,
	input  logic       q_full,
	output logic       q_push,
	output item_t      q_item
);

	logic is_cr;

	assign in_ready = !q_full;
	assign is_cr    = (data_byte == CH_CR);
	assign q_push   = in_valid && !q_full && (action || !is_cr);

	always_comb begin
		q_item.restart = action;
		q_item.digit   = data_byte[3:0];
		if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
			q_item.kind = K_DIGIT;
		end else begin
			unique case (data_byte)
				CH_LF:     q_item.kind = K_LF;
				CH_SPACE:  q_item.kind = K_SPACE;
				CH_COMMA:  q_item.kind = K_COMMA;
				CH_LPAREN: q_item.kind = K_LPAREN;
				CH_RPAREN: q_item.kind = K_RPAREN;
				default:   q_item.kind = K_OTHER;
			endcase
		end
	end

endmodule

[rtl/ftprl_queue.sv]
// ----------------------------------------------------------------------------
// ftprl_queue
// small first-in first-out queue of classified items between front and back
// ----------------------------------------------------------------------------
module ftprl_queue
	import ftprl_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	item_t         mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == FULL_COUNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_item = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/ftprl_back.sv]
// ----------------------------------------------------------------------------
// ftprl_back
// line state, size and passive-port parsing, and the result register
// ----------------------------------------------------------------------------
module ftprl_back
	import ftprl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  max_len,
	input  logic        q_not_empty,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  reply_code,
	output logic        size_valid,
	output logic [31:0] size_value,
	output logic        pasv_valid,
	output logic [15:0] pasv_port,
	output logic        line_overlong
);

	logic [7:0]  line_count_q, line_count_n;
	logic [9:0]  code_q, code_n;
	logic        prefix_ok_q, prefix_ok_n;
	logic [31:0] size_acc_q, size_acc_n;
	logic        size_ok_q, size_ok_n;
	logic        size_dig_q, size_dig_n;
	logic [3:0]  stage_q, stage_n;
	logic [7:0]  field_q, field_n;
	logic        field_dig_q, field_dig_n;
	logic [7:0]  port_hi_q, port_hi_n;
	logic [7:0]  port_lo_q, port_lo_n;
	logic        stuck_q, stuck_n;

	logic        out_valid_q;
	logic [9:0]  code_out_q;
	logic        size_valid_q;
	logic [31:0] size_value_q;
	logic        pasv_valid_q;
	logic [15:0] pasv_port_q;
	logic        overlong_q;

	logic        emit;
	logic [9:0]  r_code;
	logic        r_size_valid;
	logic [31:0] r_size_value;
	logic        r_pasv_valid;
	logic [15:0] r_pasv_port;
	logic        r_overlong;
	logic        do_clear;
	logic        digit;
	logic [13:0] code_mul;
	logic [35:0] size_mul;
	logic [11:0] field_mul;
	logic [15:0] port_word;
	logic        sv;
	logic        pv;

	assign q_pop     = q_not_empty && (!out_valid_q || out_ready);
	assign digit     = (q_item.kind == K_DIGIT);
	assign code_mul  = ({4'b0, code_q} << 3) + ({4'b0, code_q} << 1) + {10'b0, q_item.digit};
	assign size_mul  = ({4'b0, size_acc_q} << 3) + ({4'b0, size_acc_q} << 1)
		+ {32'b0, q_item.digit};
	assign field_mul = ({4'b0, field_q} << 3) + ({4'b0, field_q} << 1) + {8'b0, q_item.digit};
	assign port_word = {port_hi_q, port_lo_q};
	assign sv        = (code_q == SIZE_CODE) && size_ok_q && size_dig_q;
	assign pv        = (stage_q == PS_DONE) && (port_word != 16'd0);

	always_comb begin
		line_count_n = line_count_q;
		code_n       = code_q;
		prefix_ok_n  = prefix_ok_q;
		size_acc_n   = size_acc_q;
		size_ok_n    = size_ok_q;
		size_dig_n   = size_dig_q;
		stage_n      = stage_q;
		field_n      = field_q;
		field_dig_n  = field_dig_q;
		port_hi_n    = port_hi_q;
		port_lo_n    = port_lo_q;
		stuck_n      = stuck_q;
		do_clear     = 1'b0;
		emit         = 1'b0;
		r_code       = '0;
		r_size_valid = 1'b0;
		r_size_value = '0;
		r_pasv_valid = 1'b0;
		r_pasv_port  = '0;
		r_overlong   = 1'b0;

		if (q_pop) begin
			if (q_item.restart) begin
				stuck_n  = 1'b0;
				do_clear = 1'b1;
			end else if (stuck_q) begin
				stuck_n = 1'b1;
			end else if (q_item.kind == K_LF) begin
				do_clear = 1'b1;
				if (line_count_q >= MIN_LINE_LEN && prefix_ok_q) begin
					emit         = 1'b1;
					r_code       = code_q;
					r_size_valid = sv;
					r_size_value = sv ? size_acc_q : 32'd0;
					r_pasv_valid = pv;
					r_pasv_port  = pv ? port_word : 16'd0;
				end
			end else if (line_count_q >= max_len) begin
				emit       = 1'b1;
				r_overlong = 1'b1;
				stuck_n    = 1'b1;
				do_clear   = 1'b1;
			end else begin
				// reply code, separator and size digits
				if (line_count_q < PREFIX_LEN) begin
					if (digit) begin
						code_n = code_mul[9:0];
					end else begin
						prefix_ok_n = 1'b0;
					end
				end else if (line_count_q == PREFIX_LEN) begin
					if (q_item.kind != K_SPACE) begin
						prefix_ok_n = 1'b0;
					end
				end else if (size_ok_q) begin
					if (digit && size_mul[35:32] == 4'd0) begin
						size_acc_n = size_mul[31:0];
						size_dig_n = 1'b1;
					end else begin
						size_ok_n = 1'b0;
					end
				end
				// passive-mode fields
				if (stage_q == PS_BEFORE) begin
					if (q_item.kind == K_LPAREN) begin
						stage_n     = 4'd1;
						field_n     = '0;
						field_dig_n = 1'b0;
					end
				end else if (stage_q < PS_DONE) begin
					if (digit) begin
						if (field_mul[11:8] != 4'd0) begin
							stage_n = PS_BAD;
						end else begin
							field_n     = field_mul[7:0];
							field_dig_n = 1'b1;
						end
					end else if (q_item.kind == K_COMMA && stage_q <= PS_FIELD5
						&& field_dig_q) begin
						if (stage_q == PS_FIELD5) begin
							port_hi_n = field_q;
						end
						stage_n     = stage_q + 4'd1;
						field_n     = '0;
						field_dig_n = 1'b0;
					end else if (q_item.kind == K_RPAREN && stage_q == PS_FIELD6
						&& field_dig_q) begin
						port_lo_n = field_q;
						stage_n   = PS_DONE;
					end else begin
						stage_n = PS_BAD;
					end
				end
				line_count_n = line_count_q + 8'd1;
			end
		end

		if (do_clear) begin
			line_count_n = '0;
			code_n       = '0;
			prefix_ok_n  = 1'b1;
			size_acc_n   = '0;
			size_ok_n    = 1'b1;
			size_dig_n   = 1'b0;
			stage_n      = PS_BEFORE;
			field_n      = '0;
			field_dig_n  = 1'b0;
			port_hi_n    = '0;
			port_lo_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			code_q       <= '0;
			prefix_ok_q  <= 1'b1;
			size_acc_q   <= '0;
			size_ok_q    <= 1'b1;
			size_dig_q   <= 1'b0;
			stage_q      <= PS_BEFORE;
			field_q      <= '0;
			field_dig_q  <= 1'b0;
			port_hi_q    <= '0;
			port_lo_q    <= '0;
			stuck_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			line_count_q <= line_count_n;
			code_q       <= code_n;
			prefix_ok_q  <= prefix_ok_n;
			size_acc_q   <= size_acc_n;
			size_ok_q    <= size_ok_n;
			size_dig_q   <= size_dig_n;
			stage_q      <= stage_n;
			field_q      <= field_n;
			field_dig_q  <= field_dig_n;
			port_hi_q    <= port_hi_n;
			port_lo_q    <= port_lo_n;
			stuck_q      <= stuck_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_out_q   <= r_code;
			size_valid_q <= r_size_valid;
			size_value_q <= r_size_value;
			pasv_valid_q <= r_pasv_valid;
			pasv_port_q  <= r_pasv_port;
			overlong_q   <= r_overlong;
		end
	end

	assign out_valid     = out_valid_q;
	assign reply_code    = code_out_q;
	assign size_valid    = size_valid_q;
	assign size_value    = size_value_q;
	assign pasv_valid    = pasv_valid_q;
	assign pasv_port     = pasv_port_q;
	assign line_overlong = overlong_q;

endmodule

[rtl/ftp_reply_line_parser.sv]
// ----------------------------------------------------------------------------
// ftp_reply_line_parser
// parses control-channel reply lines into reply code, size and passive port
// ----------------------------------------------------------------------------
// The block takes one byte transfer per clock while the queue is not full.
// Carriage returns are dropped at the input; every other byte passes through
// a QUEUE_DEPTH-entry queue to the parser, which updates its line state as it
// pops each byte. A result is registered at the output when the parser
// pops the line feed (or the character that makes the line overlong).
// While a result waits for out_ready the parser holds, and input keeps
// flowing until the queue fills.
// The max_line_length register is written through cfg_wr_en/cfg_wr_data,
// resets to 255 and should only be changed while no line is in progress.
// ----------------------------------------------------------------------------
module ftp_reply_line_parser
	import ftprl_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  reply_code,
	output logic        size_valid,
	output logic [31:0] size_value,
	output logic        pasv_valid,
	output logic [15:0] pasv_port,
	output logic        line_overlong
);

	logic [7:0] max_len_q;
	logic       q_full;
	logic       q_push;
	item_t      push_item;
	logic       q_pop;
	logic       q_not_empty;
	item_t      head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	ftprl_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	ftprl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	ftprl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_len       (max_len_q),
		.q_not_empty   (q_not_empty),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.reply_code    (reply_code),
		.size_valid    (size_valid),
		.size_value    (size_value),
		.pasv_valid    (pasv_valid),
		.pasv_port     (pasv_port),
		.line_overlong (line_overlong)
	);

endmodule

[rtl/ftprl_checker.sv]
// ----------------------------------------------------------------------------
// ftprl_checker
// port-level checks on the result channel of the reply line parser
// ----------------------------------------------------------------------------
module ftprl_checker
	import ftprl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  reply_code,
	input logic        size_valid,
	input logic [31:0] size_value,
	input logic        pasv_valid,
	input logic [15:0] pasv_port,
	input logic        line_overlong
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reply_code)
			&& $stable(size_value) && $stable(pasv_port) && $stable(line_overlong))
		else $error("result changed while stalled");

	a_overlong_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_overlong |-> reply_code == 10'd0 && !size_valid
			&& size_value == 32'd0 && !pasv_valid && pasv_port == 16'd0)
		else $error("overlong result with nonzero fields");

	a_size_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && size_valid |-> reply_code == SIZE_CODE)
		else $error("size valid on a non-size reply");

	a_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !size_valid |-> size_value == 32'd0)
		else $error("size value without size valid");

	a_pasv_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pasv_valid == (pasv_port != 16'd0)))
		else $error("passive port and valid disagree");

endmodule

bind ftp_reply_line_parser ftprl_checker u_ftprl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.reply_code    (reply_code),
	.size_valid    (size_valid),
	.size_value    (size_value),
	.pasv_valid    (pasv_valid),
	.pasv_port     (pasv_port),
	.line_overlong (line_overlong)
);

[tb/sv/ftp_reply_checker.sv]
// ----------------------------------------------------------------------------
// ftp_reply_checker
// Watches the byte and reply channels of the reply line parser. Every
// accepted byte goes through a cycle-free line model: reply code, SIZE value
// and passive port. The replies that the line model produces are queued, and
// each accepted reply is compared field by field with the oldest one. Writes
// to the line limit register are tracked from the configuration port.
// ----------------------------------------------------------------------------
module ftp_reply_checker
	import ftprl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [9:0]  reply_code,
	input  logic        size_valid,
	input  logic [31:0] size_value,
	input  logic        pasv_valid,
	input  logic [15:0] pasv_port,
	input  logic        line_overlong,
	output int          fail_count,
	output int          replies_waiting,
	output int          replies_checked,
	output int          overlong_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] PS_FIELD1 = 4'd1;

	typedef struct packed {
		logic [9:0]  code;
		logic        size_ok;
		logic [31:0] size;
		logic        pasv_ok;
		logic [15:0] port;
		logic        overlong;
	} reply_t;

	reply_t expected_replies[$];

	logic [7:0]  line_limit;
	logic [7:0]  char_count;
	logic [9:0]  code_acc;
	logic        prefix_good;
	logic [31:0] size_acc;
	logic        size_good;
	logic        size_digit_seen;
	logic [3:0]  port_stage;
	logic [7:0]  field_acc;
	logic        field_digit_seen;
	logic [7:0]  port_hi;
	logic [7:0]  port_lo;
	logic        silenced;
	int          errors;
	int          checked;
	int          overlong_count;

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= CH_ZERO && ch <= CH_NINE;
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("reply %0d: %s is %0d, expected %0d",
				checked, name, got, want));
		end
	endtask

	task automatic clear_line_state();
		char_count       = '0;
		code_acc         = '0;
		prefix_good      = 1'b1;
		size_acc         = '0;
		size_good        = 1'b1;
		size_digit_seen  = 1'b0;
		port_stage       = PS_BEFORE;
		field_acc        = '0;
		field_digit_seen = 1'b0;
		port_hi          = '0;
		port_lo          = '0;
	endtask

	task automatic track_pasv(input logic [7:0] ch);
		logic [11:0] wide;
		if (port_stage == PS_BEFORE) begin
			if (ch == CH_LPAREN) begin
				port_stage       = PS_FIELD1;
				field_acc        = '0;
				field_digit_seen = 1'b0;
			end
			return;
		end
		if (port_stage >= PS_DONE)
			return;
		if (is_digit(ch)) begin
			wide = field_acc * 12'd10 + 12'(ch - CH_ZERO);
			if (wide > 12'd255) begin
				port_stage = PS_BAD;
			end else begin
				field_acc        = wide[7:0];
				field_digit_seen = 1'b1;
			end
		end else if (ch == CH_COMMA && port_stage <= PS_FIELD5 && field_digit_seen) begin
			if (port_stage == PS_FIELD5)
				port_hi = field_acc;
			port_stage       = port_stage + 4'd1;
			field_acc        = '0;
			field_digit_seen = 1'b0;
		end else if (ch == CH_RPAREN && port_stage == PS_FIELD6 && field_digit_seen) begin
			port_lo    = field_acc;
			port_stage = PS_DONE;
		end else begin
			port_stage = PS_BAD;
		end
	endtask

	task automatic track_char(input logic [7:0] ch);
		logic [35:0] wide;
		if (char_count < PREFIX_LEN) begin
			if (is_digit(ch))
				code_acc = code_acc * 10'd10 + 10'(ch - CH_ZERO);
			else
				prefix_good = 1'b0;
		end else if (char_count == PREFIX_LEN) begin
			if (ch != CH_SPACE)
				prefix_good = 1'b0;
		end else if (size_good) begin
			if (is_digit(ch)) begin
				wide = size_acc * 36'd10 + 36'(ch - CH_ZERO);
				if (wide > 36'hFFFF_FFFF) begin
					size_good = 1'b0;
				end else begin
					size_acc        = wide[31:0];
					size_digit_seen = 1'b1;
				end
			end else begin
				size_good = 1'b0;
			end
		end
		track_pasv(ch);
		char_count = char_count + 8'd1;
	endtask

	task automatic predict_reply(input logic act, input logic [7:0] ch);
		reply_t r;
		logic [15:0] port;
		r = '0;
		if (act) begin
			silenced = 1'b0;
			clear_line_state();
			return;
		end
		if (silenced || ch == CH_CR)
			return;
		if (ch != CH_LF) begin
			if (char_count >= line_limit) begin
				r.overlong = 1'b1;
				expected_replies.push_back(r);
				silenced = 1'b1;
				clear_line_state();
				return;
			end
			track_char(ch);
			return;
		end
		if (char_count >= MIN_LINE_LEN && prefix_good) begin
			port      = {port_hi, port_lo};
			r.code    = code_acc;
			r.size_ok = code_acc == SIZE_CODE && size_good && size_digit_seen;
			r.size    = r.size_ok ? size_acc : '0;
			r.pasv_ok = port_stage == PS_DONE && port != '0;
			r.port    = r.pasv_ok ? port : '0;
			expected_replies.push_back(r);
		end
		clear_line_state();
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			line_limit = LIMIT_RESET;
			silenced   = 1'b0;
			clear_line_state();
			expected_replies.delete();
			errors           = 0;
			checked          = 0;
			overlong_count   = 0;
			fail_count       <= 0;
			replies_waiting  <= 0;
			replies_checked  <= 0;
			overlong_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got.code     = reply_code;
				got.size_ok  = size_valid;
				got.size     = size_value;
				got.pasv_ok  = pasv_valid;
				got.port     = pasv_port;
				got.overlong = line_overlong;
				if (expected_replies.size() == 0) begin
					report_error($sformatf("reply transfer with none expected (code %0d)",
						got.code));
				end else begin
					want = expected_replies.pop_front();
					check_field("reply_code", 32'(got.code), 32'(want.code));
					check_field("size_valid", 32'(got.size_ok), 32'(want.size_ok));
					check_field("size_value", got.size, want.size);
					check_field("pasv_valid", 32'(got.pasv_ok), 32'(want.pasv_ok));
					check_field("pasv_port", 32'(got.port), 32'(want.port));
					check_field("line_overlong", 32'(got.overlong), 32'(want.overlong));
					if (want.overlong)
						overlong_count++;
				end
				checked++;
			end
			if (cfg_wr_en)
				line_limit = cfg_wr_data;
			if (in_valid && in_ready)
				predict_reply(action, data_byte);
			fail_count       <= errors;
			replies_waiting  <= expected_replies.size();
			replies_checked  <= checked;
			overlong_checked <= overlong_count;
		end
	end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the reply line parser. A few directed lines come
// first, then phases of random reply lines (SIZE and passive replies with
// random content, plain and continuation lines, short lines, broken lines,
// noise and restarts), each phase under its own line limit, zero and 255
// among them. Both channels idle at random; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb
	import ftprl_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET    = 1350;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  reply_code;
	logic        size_valid;
	logic [31:0] size_value;
	logic        pasv_valid;
	logic [15:0] pasv_port;
	logic        line_overlong;

	int fail_count;
	int replies_waiting;
	int replies_checked;
	int overlong_checked;

	logic [7:0] line_buf[$];
	int         items_sent;
	int         transfers;
	int         phase_count;
	bit         in_calm;
	bit         out_calm;
	int         replies_taken;
	int         idle_cycles;

	always #4ns clk = ~clk;

	ftp_reply_line_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.reply_code   (reply_code),
		.size_valid   (size_valid),
		.size_value   (size_value),
		.pasv_valid   (pasv_valid),
		.pasv_port    (pasv_port),
		.line_overlong(line_overlong)
	);

	ftp_reply_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.reply_code      (reply_code),
		.size_valid      (size_valid),
		.size_value      (size_value),
		.pasv_valid      (pasv_valid),
		.pasv_port       (pasv_port),
		.line_overlong   (line_overlong),
		.fail_count      (fail_count),
		.replies_waiting (replies_waiting),
		.replies_checked (replies_checked),
		.overlong_checked(overlong_checked)
	);

	// byte channel: valid stays up across back-to-back transfers
	task automatic send_item(input logic act, input logic [7:0] b);
		int gap;
		if (transfers % 50 == 0)
			in_calm = ($urandom_range(0, 3) == 0);
		gap = in_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		transfers++;
		items_sent++;
	endtask

	task automatic send_restart();
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_line();
		foreach (line_buf[i]) begin
			if ($urandom_range(0, 149) == 0)
				send_restart();
			send_item(1'b0, line_buf[i]);
		end
		line_buf.delete();
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic put_num(input longint unsigned v);
		put_str($sformatf("%0d", v));
	endtask

	task automatic put_code();
		for (int i = 0; i < 3; i++)
			line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic put_letters(input int n);
		for (int i = 0; i < n; i++)
			line_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
	endtask

	task automatic put_text(input int n);
		for (int i = 0; i < n; i++)
			line_buf.push_back(8'($urandom_range(32, 126)));
	endtask

	task automatic put_eol();
		if ($urandom_range(0, 9) < 7)
			line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
	endtask

	task automatic build_size_line();
		if ($urandom_range(0, 9) < 9)
			put_str("213 ");
		else begin
			put_code();
			line_buf.push_back(CH_SPACE);
		end
		case ($urandom_range(0, 9))
			0: put_num($urandom_range(0, 999));
			1, 2: put_num($urandom());
			3: put_str("4294967295");
			4: put_num(64'd4294967296 + $urandom_range(0, 1000));
			5: begin
				put_str("000");
				put_num($urandom());
			end
			6: ;
			7: begin
				put_num($urandom_range(0, 99999));
				put_text(1);
			end
			8: put_str("99999999999");
			default: put_num($urandom_range(0, 9));
		endcase
		put_eol();
	endtask

	task automatic build_pasv_line();
		bit zero_port;
		zero_port = ($urandom_range(0, 19) == 0);
		if ($urandom_range(0, 4) != 0)
			put_str("227 ");
		else begin
			put_code();
			line_buf.push_back(CH_SPACE);
		end
		if ($urandom_range(0, 9) < 4)
			put_str("Entering Passive Mode ");
		else
			put_letters($urandom_range(0, 3));
		line_buf.push_back(CH_LPAREN);
		for (int f = 0; f < 6; f++) begin
			if (zero_port && f >= 4)
				put_num(0);
			else begin
				case ($urandom_range(0, 19))
					0: ;
					1: put_num($urandom_range(256, 999));
					2: begin
						put_num(0);
						put_num($urandom_range(0, 255));
					end
					3: put_num(0);
					4: put_num(255);
					default: put_num($urandom_range(0, 255));
				endcase
			end
			if ($urandom_range(0, 29) == 0)
				put_text(1);
			else if (f < 5)
				line_buf.push_back(CH_COMMA);
			else
				line_buf.push_back(CH_RPAREN);
		end
		if ($urandom_range(0, 9) < 4)
			put_text($urandom_range(1, 3));
		put_eol();
	endtask

	task automatic build_boundary_line(input int limit);
		int len;
		len = (limit == 0) ? $urandom_range(0, 1) : limit - 1 + $urandom_range(0, 2);
		if (len >= 4) begin
			put_code();
			line_buf.push_back(CH_SPACE);
			put_letters(len - 4);
		end else begin
			put_letters(len);
		end
		put_eol();
	endtask

	task automatic build_line(input int limit);
		int choice;
		int pos;
		choice = $urandom_range(0, 99);
		if (choice < 22) begin
			build_size_line();
		end else if (choice < 44) begin
			build_pasv_line();
		end else if (choice < 58) begin
			put_code();
			line_buf.push_back(CH_SPACE);
			put_text($urandom_range(0, 12));
			put_eol();
		end else if (choice < 67) begin
			// continuation lines
			if ($urandom_range(0, 1)) begin
				put_code();
				put_str("-");
			end else begin
				line_buf.push_back(CH_SPACE);
			end
			put_text($urandom_range(0, 10));
			put_eol();
		end else if (choice < 75) begin
			for (int i = $urandom_range(0, 3); i > 0; i--)
				line_buf.push_back($urandom_range(0, 1) ? CH_ZERO + 8'($urandom_range(0, 9))
					: 8'($urandom_range(32, 126)));
			put_eol();
		end else if (choice < 85) begin
			for (int i = $urandom_range(1, 20); i > 0; i--)
				line_buf.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) < 3)
				line_buf.push_back(CH_LF);
		end else if (choice < 95 || (limit > 64 && choice < 99)) begin
			if ($urandom_range(0, 1))
				build_size_line();
			else
				build_pasv_line();
			pos = $urandom_range(0, line_buf.size() - 1);
			line_buf[pos] = 8'($urandom_range(0, 255));
		end else begin
			build_boundary_line(limit);
		end
	endtask

	// only called with no line in progress; waits until no reply is outstanding
	task automatic settle_and_set_limit(input logic [7:0] limit);
		in_valid <= 1'b0;
		do @(posedge clk); while (replies_waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		phase_count++;
	endtask

	// reply channel
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (replies_taken % 20 == 0)
				out_calm = ($urandom_range(0, 3) == 0);
			stall = out_calm ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			replies_taken++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] limits[12];
		logic [7:0] limit;
		int         budget;
		int         phase_start;
		int         idx;
		limits = '{8'd0, 8'd1, 8'd3, 8'd4, 8'd5, 8'd255, 8'd12, 8'd40, 8'd255,
			8'd200, 8'd6, 8'd255};
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		action      <= 1'b0;
		data_byte   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: restart while idle, SIZE line, short line, code extremes
		send_restart();
		put_str("213 7");
		put_eol();
		put_str("12");
		line_buf.push_back(CH_LF);
		put_str("999 ");
		line_buf.push_back(8'hFF);
		line_buf.push_back(CH_LF);
		put_str("000 ");
		line_buf.push_back(8'h00);
		line_buf.push_back(CH_LF);
		send_line();
		send_restart();

		idx = 0;
		while (items_sent < ITEM_TARGET) begin
			if (idx < 12)
				limit = limits[idx];
			else
				limit = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(6, 80));
			settle_and_set_limit(limit);
			budget      = (limit < 8) ? 40 : 150;
			phase_start = items_sent;
			if (limit <= 64 || idx == 5) begin
				build_boundary_line(limit);
				send_line();
			end
			while (items_sent - phase_start < budget) begin
				build_line(limit);
				send_line();
				if ($urandom_range(0, 99) < ((limit < 8) ? 50 : 8))
					send_restart();
			end
			send_restart();
			idx++;
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (replies_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d byte and restart transfers under %0d line limit settings",
			items_sent, phase_count);
		$display("checked %0d replies, %0d of them overlong", replies_checked,
			overlong_checked);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
